FILE: rtl/npwr_pkg.sv
// ----------------------------------------------------------------------------
// npwr_pkg
// Shared constants, result codes and the command and status bundles that
// pass between the controller and the datapath of the nearest point search.
// ----------------------------------------------------------------------------
package npwr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int LON_W   = 25;
    localparam int LAT_W   = 24;
    localparam int PROX_W  = 25;
    localparam int ENTRY_W = 10;
    localparam int STAT_W  = 2;

    localparam int SQLON_W = 2 * LON_W;
    localparam int SQLAT_W = 2 * LAT_W;
    localparam int DIST_W  = SQLON_W + 1;
    localparam int PSQ_W   = 2 * PROX_W;

    localparam logic [PROX_W-1:0] PROX_RESET = PROX_W'(65536);

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_FOUND = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // latch the coordinates and restart the scan
        logic do_add;        // append the point or report a full table
        logic scan_step;     // read one stored point into the pipeline
        logic finish_query;  // deliver the query result
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic empty;         // no points stored
        logic last_issue;    // the current scan address is the last point
        logic pipe_idle;     // no point is left in the distance pipeline
    } t_dp_stat;

endpackage

FILE: rtl/npwr_ctrl.sv
// ----------------------------------------------------------------------------
// npwr_ctrl
// Controller of the nearest point search: takes transactions, sequences the
// add, the table scan and the pipeline drain.
// ----------------------------------------------------------------------------
module npwr_ctrl
    import npwr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_kind,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ADD   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.capture      = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_kind) begin
                        n_state = S_ADD;
                    end else if (i_stat.empty) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    o_cmd.finish_query = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/npwr_dp.sv
// ----------------------------------------------------------------------------
// npwr_dp
// Datapath of the nearest point search: point memory, point count, radius
// register, squared distance pipeline, running minimum and result register.
// ----------------------------------------------------------------------------
module npwr_dp
    import npwr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [LON_W-1:0]   i_longitude,
    input  logic [LAT_W-1:0]   i_latitude,
    input  logic               i_prox_we,
    input  logic [PROX_W-1:0]  i_prox_wdata,
    output t_dp_stat           o_stat,
    output logic               o_done,
    output logic [STAT_W-1:0]  o_status,
    output logic [ENTRY_W-1:0] o_entry_index
);

    // Point memory, read with a registered port.
    logic [LON_W-1:0] mem_lon [TABLE_DEPTH];
    logic [LAT_W-1:0] mem_lat [TABLE_DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [PROX_W-1:0] r_prox;
    logic [PSQ_W-1:0]  r_prox_sq;
    logic [LON_W-1:0]  r_lon;
    logic [LAT_W-1:0]  r_lat;
    logic [IDX_W-1:0]  r_addr;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]  r_i1, r_i2, r_i3, r_i4;
    logic [LON_W-1:0]  r_rd_lon;
    logic [LAT_W-1:0]  r_rd_lat;
    logic [LON_W-1:0]  r_dlon_abs;
    logic [LAT_W-1:0]  r_dlat_abs;
    logic [SQLON_W-1:0] r_sq_lon;
    logic [SQLAT_W-1:0] r_sq_lat;
    logic [DIST_W-1:0] r_dist;

    logic              r_best_valid;
    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_i;

    logic              r_done;
    t_status           r_status;
    logic [ENTRY_W-1:0] r_index;

    logic              w_full;
    logic [LON_W:0]    w_dlon;
    logic [LAT_W:0]    w_dlat;
    logic              w_take;
    logic              w_found;

    assign w_full = (r_count == CNT_W'(TABLE_DEPTH));

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.last_issue = (CNT_W'(r_addr) == r_count - CNT_W'(1));
    assign o_stat.pipe_idle  = !(r_v1 || r_v2 || r_v3 || r_v4);

    // Sign-extended differences and their magnitudes.
    assign w_dlon = {r_lon[LON_W-1], r_lon} - {r_rd_lon[LON_W-1], r_rd_lon};
    assign w_dlat = {r_lat[LAT_W-1], r_lat} - {r_rd_lat[LAT_W-1], r_rd_lat};

    // The first point seen always takes the lead; later ones only when
    // strictly nearer, so ties keep the lowest index.
    assign w_take  = r_v4 && (!r_best_valid || (r_dist < r_best));
    assign w_found = r_best_valid && (r_best < DIST_W'(r_prox_sq));

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_add && !w_full) begin
            mem_lon[r_count[IDX_W-1:0]] <= r_lon;
            mem_lat[r_count[IDX_W-1:0]] <= r_lat;
        end
        r_rd_lon <= mem_lon[r_addr];
        r_rd_lat <= mem_lat[r_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prox_sq <= PSQ_W'(r_prox) * PSQ_W'(r_prox);
        if (i_cmd.capture) begin
            r_lon <= i_longitude;
            r_lat <= i_latitude;
        end
        r_i1       <= r_addr;
        r_i2       <= r_i1;
        r_i3       <= r_i2;
        r_i4       <= r_i3;
        r_dlon_abs <= w_dlon[LON_W] ? LON_W'(-w_dlon) : w_dlon[LON_W-1:0];
        r_dlat_abs <= w_dlat[LAT_W] ? LAT_W'(-w_dlat) : w_dlat[LAT_W-1:0];
        r_sq_lon   <= SQLON_W'(r_dlon_abs) * SQLON_W'(r_dlon_abs);
        r_sq_lat   <= SQLAT_W'(r_dlat_abs) * SQLAT_W'(r_dlat_abs);
        r_dist     <= DIST_W'(r_sq_lon) + DIST_W'(r_sq_lat);
        if (w_take) begin
            r_best   <= r_dist;
            r_best_i <= r_i4;
        end
        if (i_cmd.do_add) begin
            r_status <= w_full ? ST_FULL : ST_ADDED;
            r_index  <= w_full ? '0 : ENTRY_W'(r_count);
        end else if (i_cmd.finish_query) begin
            r_status <= w_found ? ST_FOUND : ST_NONE;
            r_index  <= w_found ? ENTRY_W'(r_best_i) : '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prox       <= PROX_RESET;
            r_addr       <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_best_valid <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (i_prox_we) begin
                r_prox <= i_prox_wdata;
            end
            if (i_cmd.do_add && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.capture) begin
                r_addr <= '0;
            end else if (i_cmd.scan_step) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.capture) begin
                r_best_valid <= 1'b0;
            end else if (w_take) begin
                r_best_valid <= 1'b1;
            end
            r_done <= i_cmd.do_add || i_cmd.finish_query;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_index = r_index;

endmodule

FILE: rtl/nearest_point_within_radius.sv
// ----------------------------------------------------------------------------
// nearest_point_within_radius
// Table of 2-D points with a search for the first nearest point that lies
// strictly inside a programmable radius.
// ----------------------------------------------------------------------------
// Usage. A transaction is taken at a rising edge where start is high and
// busy is low. i_kind low appends (i_longitude, i_latitude) to the table;
// i_kind high asks for the nearest stored point. Coordinates are signed
// degrees with 16 fraction bits.
// Every transaction yields exactly one result: o_done is high for one cycle
// with o_status and o_entry_index. The receiver cannot stall, so results
// must be taken as they appear.
// An add passes through the S_ADD state before its result is registered.
// A query reads one stored point per cycle through the single memory read
// port into a five-stage squared distance pipeline (memory read,
// difference, square, sum, compare), then waits in S_DRAIN until the
// pipeline is empty before its result is registered. A query on an empty
// table skips the scan. busy falls as the result is registered, so the
// next transaction may be taken while o_done is high.
// The radius register is written by i_prox_we / i_prox_wdata; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. A synchronous reset (i_rst_n low) empties the table and
// sets the radius to 1.0 degree; stored coordinates are not cleared.
// ----------------------------------------------------------------------------
module nearest_point_within_radius
    import npwr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [LON_W-1:0]   i_longitude,
    input  logic [LAT_W-1:0]   i_latitude,
    input  logic               i_prox_we,
    input  logic [PROX_W-1:0]  i_prox_wdata,
    output logic               o_done,
    output logic [STAT_W-1:0]  o_status,
    output logic [ENTRY_W-1:0] o_entry_index
);

    // Commands and status between controller and datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    npwr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    npwr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_longitude   (i_longitude),
        .i_latitude    (i_latitude),
        .i_prox_we     (i_prox_we),
        .i_prox_wdata  (i_prox_wdata),
        .o_stat        (w_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_index (o_entry_index)
    );

endmodule

FILE: verif/npwr_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npwr_tb_pkg
// Item codes and coordinate limits that the stimulus and the checker of the
// nearest point search share.
// ----------------------------------------------------------------------------
package npwr_tb_pkg;

    import npwr_pkg::*;

    // Encoding of the kind field of a transaction.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Physical ranges of the coordinates (180 and 90 degrees, 16 fraction bits).
    localparam int LON_RANGE = 11796480;
    localparam int LAT_RANGE = 5898240;

    localparam logic [PROX_W-1:0] PROX_MAX = {PROX_W{1'b1}};

endpackage

FILE: verif/npwr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npwr_checker
// Watches the transactions and results of the nearest point search, keeps its
// own copy of the point table and radius, and compares every result with the
// answer it predicts.
// ----------------------------------------------------------------------------
module npwr_checker
    import npwr_pkg::*;
    import npwr_tb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_kind,
    input  logic [LON_W-1:0]   i_longitude,
    input  logic [LAT_W-1:0]   i_latitude,
    input  logic               i_prox_we,
    input  logic [PROX_W-1:0]  i_prox_wdata,
    input  logic               i_done,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [ENTRY_W-1:0] i_entry_index,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_found_count,
    output int                 o_missed_count,
    output int                 o_full_count
);

    typedef struct packed {
        t_status              status;
        logic [ENTRY_W-1:0]   index;
    } t_answer;

    t_answer                   answers_due[$];

    logic signed [LON_W-1:0]   stored_lon [TABLE_DEPTH];
    logic signed [LAT_W-1:0]   stored_lat [TABLE_DEPTH];
    int                        stored_count;
    logic [PROX_W-1:0]         radius;

    int mismatches   = 0;
    int found_count  = 0;
    int missed_count = 0;
    int full_count   = 0;

    initial begin
        o_mismatches   = 0;
        o_outstanding  = 0;
        o_found_count  = 0;
        o_missed_count = 0;
        o_full_count   = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        longint  dlon;
        longint  dlat;
        longint  sq_span;
        longint  best;
        longint  reach_sq;
        int      best_at;
        if (!i_rst_n) begin
            answers_due.delete();
            stored_count = 0;
            radius       = PROX_RESET;
        end else begin
            // A result leaves in the same cycle as a later transaction may be
            // taken, so the result is matched before the new answer is queued.
            if (i_done) begin
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result with nothing outstanding: status %0d index %0d",
                                 i_status, i_entry_index);
                end else begin
                    want = answers_due.pop_front();
                    if (want.status != i_status || want.index != i_entry_index) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch at %0t: expected status %0d index %0d,",
                                      " got status %0d index %0d"},
                                     $realtime, want.status, want.index,
                                     i_status, i_entry_index);
                    end
                end
            end

            if (i_prox_we)
                radius = i_prox_wdata;

            if (i_start && !i_busy) begin
                want.index = '0;
                if (i_kind == KIND_ADD) begin
                    if (stored_count >= TABLE_DEPTH) begin
                        want.status = ST_FULL;
                        full_count++;
                    end else begin
                        stored_lon[stored_count] = i_longitude;
                        stored_lat[stored_count] = i_latitude;
                        want.status = ST_ADDED;
                        want.index  = ENTRY_W'(stored_count);
                        stored_count++;
                    end
                end else begin
                    want.status = ST_NONE;
                    if (stored_count > 0) begin
                        // Strict comparison keeps the lowest index among ties.
                        best    = 0;
                        best_at = 0;
                        for (int i = 0; i < stored_count; i++) begin
                            dlon = longint'($signed(i_longitude)) - longint'(stored_lon[i]);
                            dlat = longint'($signed(i_latitude)) - longint'(stored_lat[i]);
                            sq_span = dlon * dlon + dlat * dlat;
                            if (i == 0 || sq_span < best) begin
                                best    = sq_span;
                                best_at = i;
                            end
                        end
                        reach_sq = longint'(radius) * longint'(radius);
                        if (best < reach_sq) begin
                            want.status = ST_FOUND;
                            want.index  = ENTRY_W'(best_at);
                        end
                    end
                    if (want.status == ST_FOUND)
                        found_count++;
                    else
                        missed_count++;
                end
                answers_due = {answers_due, want};
            end
        end
        o_mismatches   <= mismatches;
        o_outstanding  <= answers_due.size();
        o_found_count  <= found_count;
        o_missed_count <= missed_count;
        o_full_count   <= full_count;
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the nearest point search: directed corner cases,
// then randomised adds and queries under several radius settings and sender
// idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import npwr_pkg::*;
    import npwr_tb_pkg::*;

    // Most negative and most positive bit patterns of the coordinate fields.
    localparam logic [LON_W-1:0] LON_NEG = {1'b1, {(LON_W-1){1'b0}}};
    localparam logic [LON_W-1:0] LON_POS = {1'b0, {(LON_W-1){1'b1}}};
    localparam logic [LAT_W-1:0] LAT_NEG = {1'b1, {(LAT_W-1){1'b0}}};
    localparam logic [LAT_W-1:0] LAT_POS = {1'b0, {(LAT_W-1){1'b1}}};

    // Random part: four phases of this many transactions each.
    localparam int PHASE_ITEMS = 145;

    // A query over a full table keeps the block quiet while it scans every
    // stored point; the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT = 5000;

    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic [LON_W-1:0]   longitude;
    logic [LAT_W-1:0]   latitude;
    logic               prox_we;
    logic [PROX_W-1:0]  prox_wdata;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry_index;

    int mismatches;
    int outstanding;
    int found_count;
    int missed_count;
    int full_count;

    // Points that the stimulus has stored, kept so that queries can be aimed
    // close to them; without this almost every random query would miss.
    logic [LON_W-1:0] known_lon[$];
    logic [LAT_W-1:0] known_lat[$];

    int n_adds    = 0;
    int n_queries = 0;
    int quiet_cycles = 0;

    nearest_point_within_radius dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (kind),
        .i_longitude   (longitude),
        .i_latitude    (latitude),
        .i_prox_we     (prox_we),
        .i_prox_wdata  (prox_wdata),
        .o_done        (done),
        .o_status      (status),
        .o_entry_index (entry_index)
    );

    npwr_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (kind),
        .i_longitude    (longitude),
        .i_latitude     (latitude),
        .i_prox_we      (prox_we),
        .i_prox_wdata   (prox_wdata),
        .i_done         (done),
        .i_status       (status),
        .i_entry_index  (entry_index),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_found_count  (found_count),
        .o_missed_count (missed_count),
        .o_full_count   (full_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a run that stops taking transactions and stops delivering
    // results is a failure, whatever the reason.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Presents one transaction and returns at the edge that takes it. start is
    // left high, so a following transaction can go out back to back; the
    // caller lowers it when it wants a gap.
    task automatic issue(input logic item_kind, input logic [LON_W-1:0] lon,
                         input logic [LAT_W-1:0] lat);
        start     <= 1'b1;
        kind      <= item_kind;
        longitude <= lon;
        latitude  <= lat;
        do @(posedge i_clk); while (busy);
        if (item_kind == KIND_ADD) begin
            n_adds++;
            if (known_lon.size() < TABLE_DEPTH) begin
                known_lon = {known_lon, lon};
                known_lat = {known_lat, lat};
            end
        end else begin
            n_queries++;
        end
    endtask

    // Lowers start and waits until every result has arrived and the block has
    // had time to fall idle.
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The radius is only changed while the block has nothing in flight.
    task automatic write_radius(input logic [PROX_W-1:0] value);
        wait_idle();
        prox_we    <= 1'b1;
        prox_wdata <= value;
        @(posedge i_clk);
        prox_we    <= 1'b0;
    endtask

    // One random transaction; afterwards the sender stays idle for each
    // following cycle with the given odds. Coordinates are either any bit
    // pattern, a value in the physical range, or a small offset from a point
    // already stored, which makes matches and near ties common.
    task automatic random_item(input int idle_pct);
        logic             item_kind;
        logic [LON_W-1:0] lon;
        logic [LAT_W-1:0] lat;
        int               pick;
        int               spread;
        item_kind = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_QUERY;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                lon = LON_W'($urandom);
                lat = LAT_W'($urandom);
            end
            3, 4: begin
                lon = LON_W'(int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE);
                lat = LAT_W'(int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE);
            end
            default: begin
                if (known_lon.size() == 0) begin
                    lon = LON_W'($urandom);
                    lat = LAT_W'($urandom);
                end else begin
                    pick   = $urandom_range(0, known_lon.size() - 1);
                    spread = 1 << $urandom_range(0, 17);
                    lon = known_lon[pick] + LON_W'(int'($urandom_range(0, 2 * spread)) - spread);
                    spread = 1 << $urandom_range(0, 17);
                    lat = known_lat[pick] + LAT_W'(int'($urandom_range(0, 2 * spread)) - spread);
                end
            end
        endcase
        issue(item_kind, lon, lat);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    initial begin
        int idle_pct;
        start      = 1'b0;
        kind       = KIND_ADD;
        longitude  = '0;
        latitude   = '0;
        prox_we    = 1'b0;
        prox_wdata = '0;
        i_rst_n    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset radius of one degree.
        issue(KIND_QUERY, '0, '0);                   // empty table
        issue(KIND_ADD, '0, '0);
        issue(KIND_QUERY, LON_W'(65536), '0);        // exactly on the radius
        issue(KIND_QUERY, LON_W'(65535), '0);        // just inside it
        issue(KIND_QUERY, '0, LAT_W'(-65536));
        issue(KIND_QUERY, LON_W'(39321), LAT_W'(52428)); // 3-4-5 triangle inside
        issue(KIND_ADD, LON_W'(30000), LAT_W'(500));
        issue(KIND_ADD, LON_W'(30000), LAT_W'(500)); // duplicate point
        issue(KIND_QUERY, LON_W'(30000), LAT_W'(500)); // tie on identical points
        issue(KIND_ADD, LON_W'(50000), LAT_W'(10000));
        issue(KIND_ADD, LON_W'(50000), LAT_W'(-10000));
        issue(KIND_QUERY, LON_W'(50000), '0);        // tie on mirrored points
        issue(KIND_ADD, LON_NEG, LAT_NEG);
        issue(KIND_QUERY, LON_NEG, LAT_NEG);
        issue(KIND_QUERY, LON_POS, LAT_POS);         // far from every point
        issue(KIND_ADD, LON_POS, LAT_POS);
        issue(KIND_QUERY, LON_POS - LON_W'(1), LAT_POS);

        // The widest radius catches almost anything; the zero radius nothing,
        // not even a point at distance zero.
        write_radius(PROX_MAX);
        issue(KIND_QUERY, LON_POS, LAT_NEG);
        issue(KIND_QUERY, LON_NEG, LAT_POS);
        write_radius('0);
        issue(KIND_QUERY, '0, '0);

        // Random part: each phase sets a radius and a sender idling rate.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_radius(PROX_W'($urandom_range(1, 200000)));
                    idle_pct = 0;
                end
                1: begin
                    write_radius(PROX_MAX);
                    idle_pct = 81;
                end
                2: begin
                    write_radius(PROX_W'($urandom_range(1, 5000)));
                    idle_pct = 25;
                end
                default: begin
                    write_radius(PROX_W'($urandom));
                    idle_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) random_item(idle_pct);
        end
        repeat (6) random_item(25);

        wait_idle();
        $display("Run covered %0d adds and %0d queries over seven radius settings.",
                 n_adds, n_queries);
        $display("Queries matched %0d times and missed %0d times; %0d adds met a full table.",
                 found_count, missed_count, full_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/npwr_pkg.sv
rtl/npwr_ctrl.sv
rtl/npwr_dp.sv
rtl/nearest_point_within_radius.sv
verif/npwr_tb_pkg.sv
verif/npwr_checker.sv
verif/testbench.sv
